[hw/rtl/b64e_pkg.sv]
// shared types, constants and the symbol map of the base64 line encoder
// no dependencies
package b64e_pkg;

   localparam logic       CMD_ENCODE = 1'b0;
   localparam logic       CMD_FINISH = 1'b1;

   localparam logic [7:0] DEFAULT_GROUPS_PER_LINE = 8'd19;
   localparam logic [7:0] GROUP_COUNT_MAX         = 8'd255;

   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
   localparam logic [6:0] CHAR_PLUS    = 7'h2B;
   localparam logic [6:0] CHAR_SLASH   = 7'h2F;
   localparam logic [6:0] CHAR_PAD     = 7'h3D;
   localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

   localparam int         MAX_CHARS = 3;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_ONE  = 3'b010,
      PHASE_TWO  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0]                count;
      logic [MAX_CHARS-1:0][6:0] chars;
   } burst_type;

   function automatic logic [6:0] b64_symbol(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd26) begin
         c = CHAR_UPPER_A + {1'b0, v};
      end else if (v < 6'd52) begin
         c = CHAR_LOWER_A + ({1'b0, v} - 7'd26);
      end else if (v < 6'd62) begin
         c = CHAR_DIGIT_0 + ({1'b0, v} - 7'd52);
      end else if (v == 6'd62) begin
         c = CHAR_PLUS;
      end else begin
         c = CHAR_SLASH;
      end
      return c;
   endfunction

endpackage

[hw/rtl/b64e_if.sv]
// valid/ready channel interfaces for the base64 line encoder
// no dependencies
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

[hw/rtl/b64e_core.sv]
// encoder state, line register and per-item character burst
// depends on b64e_pkg
module b64e_core
   import b64e_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic      fire,
   input  logic      command,
   input  logic [7:0] data_byte,
   output burst_type burst
);

   phase_type  phase_ff, phase_in;
   logic [5:0] carry_ff, carry_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] gpl_ff, gpl_in;

   assign gpl_in = csr_wr_en ? csr_wr_data : gpl_ff;

   always_comb begin
      phase_in    = phase_ff;
      carry_in    = carry_ff;
      count_in    = count_ff;
      burst.count = 2'd0;
      burst.chars = '0;
      if (command == CMD_FINISH) begin
         case (phase_ff)
            PHASE_ONE: begin
               burst.count    = 2'd3;
               burst.chars[0] = b64_symbol(carry_ff);
               burst.chars[1] = CHAR_PAD;
               burst.chars[2] = CHAR_PAD;
            end
            PHASE_TWO: begin
               burst.count    = 2'd2;
               burst.chars[0] = b64_symbol(carry_ff);
               burst.chars[1] = CHAR_PAD;
            end
            default: begin
               burst.count = 2'd0;
            end
         endcase
         phase_in = PHASE_IDLE;
         carry_in = '0;
         count_in = '0;
      end else begin
         case (phase_ff)
            PHASE_ONE: begin
               burst.count    = 2'd1;
               burst.chars[0] = b64_symbol(carry_ff | {2'b00, data_byte[7:4]});
               carry_in       = {data_byte[3:0], 2'b00};
               phase_in       = PHASE_TWO;
            end
            PHASE_TWO: begin
               burst.count    = 2'd2;
               burst.chars[0] = b64_symbol(carry_ff | {4'b0000, data_byte[7:6]});
               burst.chars[1] = b64_symbol(data_byte[5:0]);
               carry_in       = '0;
               phase_in       = PHASE_IDLE;
               if (count_ff != GROUP_COUNT_MAX) begin
                  count_in = count_ff + 8'd1;
               end
            end
            default: begin
               if (count_ff >= gpl_ff) begin
                  burst.count    = 2'd2;
                  burst.chars[0] = CHAR_NEWLINE;
                  burst.chars[1] = b64_symbol(data_byte[7:2]);
                  count_in       = '0;
               end else begin
                  burst.count    = 2'd1;
                  burst.chars[0] = b64_symbol(data_byte[7:2]);
               end
               carry_in = {data_byte[1:0], 4'b0000};
               phase_in = PHASE_ONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         carry_ff <= '0;
         count_ff <= '0;
         gpl_ff   <= DEFAULT_GROUPS_PER_LINE;
      end else begin
         gpl_ff <= gpl_in;
         if (fire) begin
            phase_ff <= phase_in;
            carry_ff <= carry_in;
            count_ff <= count_in;
         end
      end
   end

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && command == CMD_FINISH) |=> (phase_ff == PHASE_IDLE && count_ff == 8'd0
                                           && carry_ff == 6'd0))
      else $error("finish did not clear encoder state");

   a_group_count: assert property (@(posedge clock) disable iff (reset)
      (fire && command == CMD_ENCODE && phase_ff == PHASE_TWO
       && count_ff != GROUP_COUNT_MAX) |=> (count_ff == $past(count_ff) + 8'd1))
      else $error("completed group not counted");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("encoder phase not one-hot");

endmodule

[hw/rtl/b64e_ser.sv]
// result register that sends a burst of up to three characters one per cycle while rsp.ready is high
// depends on b64e_pkg and b64e_if
module b64e_ser
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  burst_type    burst,
   output logic         free,
   b64e_rsp_if.source   rsp
);

   logic [1:0]           left_ff, left_in;
   logic [MAX_CHARS-1:0][6:0] chars_ff, chars_in;
   logic                 take;

   assign take = rsp.valid && rsp.ready;
   assign free = (left_ff == 2'd0) || (left_ff == 2'd1 && rsp.ready);

   always_comb begin
      left_in  = left_ff;
      chars_in = chars_ff;
      if (load) begin
         left_in  = burst.count;
         chars_in = burst.chars;
      end else if (take) begin
         left_in     = left_ff - 2'd1;
         chars_in[0] = chars_ff[1];
         chars_in[1] = chars_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   assign rsp.valid       = (left_ff != 2'd0);
   assign rsp.out_char    = chars_ff[0];
   assign rsp.last_of_run = (left_ff == 2'd1);

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("item shown right after reset");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp.valid || (take && rsp.last_of_run)))
      else $error("burst loaded over pending characters");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (take && rsp.last_of_run && !load) |=> !rsp.valid)
      else $error("characters after last of run");

endmodule

[hw/rtl/base64_line_wrapped_encoder.sv]
// base64 encoder with line wrapping: top level
// latency: the first character of an item is offered the cycle after it is accepted
// throughput: one character per cycle while rsp_ch.ready is high; an item holds the port until
// its last character is taken, and the next item is taken with that last character
// reset: phase, carry and group count cleared, groups per line set to 19
module base64_line_wrapped_encoder
   import b64e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req_ch,
   b64e_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   burst_type burst;
   logic      free;
   logic      fire;

   assign req_ch.ready = free;
   assign fire         = req_ch.valid && free;

   b64e_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .command     (req_ch.command),
      .data_byte   (req_ch.data_byte),
      .burst       (burst)
   );

   b64e_ser u_ser (
      .clock (clock),
      .reset (reset),
      .load  (fire),
      .burst (burst),
      .free  (free),
      .rsp   (rsp_ch)
   );

endmodule
